// ===== rtl/core/gbps_pkg.sv =====
// shared types, widths and codes of the grid bucketed point selector
`timescale 1ns / 1ps

package gbps_pkg;

    localparam int GRID_COLS_DEF = 256;
    localparam int GRID_ROWS_DEF = 256;

    localparam int COORD_W   = 16;
    localparam int PIX_W     = 13;
    localparam int SCALE_W   = 8;
    localparam int COUNT_W   = 16;
    localparam int VERDICT_W = 3;
    localparam int EPOCH_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_GRID_SCALE   = 2'd2,
        CFG_MAX_POINTS   = 2'd3
    } t_cfg_index;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT   = 3'd0,
        V_LIMIT    = 3'd1,
        V_OUTSIDE  = 3'd2,
        V_TAKEN    = 3'd3,
        V_OVERFLOW = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_READ,
        ST_CHECK
    } t_state;

endpackage

// ===== rtl/core/grid_bucketed_point_selector.sv =====
// top level: config registers, item sequencer, divider lanes and occupancy store
`timescale 1ns / 1ps

// Takes one candidate point per start (accepted when start is high and busy is low) and
// gives exactly one result, flagged by o_result_valid for a single cycle; the receiver
// cannot stall and must take it then. A point rejected on the limit or the image bounds
// is answered from SETUP through the result register, after an extra SETUP pass when
// start_set is high. A point inside the image goes through the bit-serial cell divide,
// 13 quotient steps for both axes in parallel, then a done strobe; a cell beyond the
// grid is answered when the divide is done, otherwise one occupancy read (READ) and,
// for a free cell, one write back (CHECK) follow before the result; busy drops in the
// cycle the result appears. The occupancy store holds a set stamp per cell, so start_set
// normally only advances the stamp; after reset and on every 255th start_set the store
// is wiped one cell per cycle, all GRID_COLS*GRID_ROWS cells (65536 at the defaults),
// with busy high. Config writes are always taken and must only be made while busy is low
// and no result is pending.

module grid_bucketed_point_selector #(
    parameter int GRID_COLS = gbps_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = gbps_pkg::GRID_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_start_set,
    input  logic signed [gbps_pkg::COORD_W-1:0] i_pixel_x,
    input  logic signed [gbps_pkg::COORD_W-1:0] i_pixel_y,
    output logic                              o_result_valid,
    output logic                              o_accepted,
    output logic [gbps_pkg::VERDICT_W-1:0]    o_verdict,
    output logic [gbps_pkg::COUNT_W-1:0]      o_selected_count,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [gbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gbps_pkg::CFG_DAT_W-1:0]    i_cfg_data
);

    localparam int CELLS  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW     = gbps_pkg::PIX_W;
    localparam int EW     = gbps_pkg::EPOCH_W;
    localparam int CW     = gbps_pkg::COUNT_W;
    localparam int XW     = gbps_pkg::COORD_W;

    gbps_pkg::t_state r_state, n_state;

    logic [PW-1:0]                 r_img_w;
    logic [PW-1:0]                 r_img_h;
    logic [gbps_pkg::SCALE_W-1:0]  r_scale;
    logic [CW-1:0]                 r_max;

    logic                          r_set;
    logic [XW-1:0]                 r_x;
    logic [XW-1:0]                 r_y;
    logic [CW-1:0]                 r_count;
    logic [EW-1:0]                 r_epoch;
    logic [ADDR_W-1:0]             r_clr_addr;
    logic [ADDR_W-1:0]             r_addr;

    logic                          r_res_valid;
    logic                          r_res_accepted;
    gbps_pkg::t_verdict            r_res_verdict;
    logic [CW-1:0]                 r_res_count;

    logic                          w_div_start, w_done_x, w_done_y;
    logic [PW-1:0]                 w_qx, w_qy;
    logic [gbps_pkg::SCALE_W-1:0]  w_scale;

    logic                          w_limit, w_outside, w_overflow, w_taken, w_clr_last;
    logic [ADDR_W-1:0]             w_addr;
    logic [EW-1:0]                 w_rdata;

    logic                          w_emit;
    gbps_pkg::t_verdict            w_verdict;
    logic                          w_mem_we, w_mem_re;
    logic [ADDR_W-1:0]             w_mem_waddr;
    logic [EW-1:0]                 w_mem_wdata;
    logic                          w_accept_item;

    // ---------------- config ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= PW'(640);
            r_img_h <= PW'(480);
            r_scale <= gbps_pkg::SCALE_W'(16);
            r_max   <= CW'(150);
        end else if (i_cfg_valid) begin
            case (gbps_pkg::t_cfg_index'(i_cfg_index))
                gbps_pkg::CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data[PW-1:0];
                gbps_pkg::CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data[PW-1:0];
                gbps_pkg::CFG_GRID_SCALE:   r_scale <= i_cfg_data[gbps_pkg::SCALE_W-1:0];
                gbps_pkg::CFG_MAX_POINTS:   r_max   <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- checks ----------------
    assign w_accept_item = start && !busy;
    assign w_scale   = (r_scale == '0) ? gbps_pkg::SCALE_W'(1) : r_scale;
    assign w_limit   = (r_count >= r_max);
    assign w_outside = r_x[XW-1] || r_y[XW-1] ||
                       (r_x[XW-2:0] >= (XW-1)'(r_img_w)) ||
                       (r_y[XW-2:0] >= (XW-1)'(r_img_h));
    assign w_overflow = (w_qx >= PW'(GRID_COLS)) || (w_qy >= PW'(GRID_ROWS));
    assign w_addr     = ADDR_W'(ADDR_W'(w_qy) * ADDR_W'(GRID_COLS)) + ADDR_W'(w_qx);
    assign w_taken    = (w_rdata == r_epoch);
    assign w_clr_last = (r_clr_addr == ADDR_W'(CELLS - 1));

    // ---------------- divider lanes ----------------
    gbps_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_x[PW-1:0]),
        .i_divisor  (w_scale),
        .o_done     (w_done_x),
        .o_quotient (w_qx)
    );

    gbps_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_y[PW-1:0]),
        .i_divisor  (w_scale),
        .o_done     (w_done_y),
        .o_quotient (w_qy)
    );

    // ---------------- occupancy store: one set stamp per cell ----------------
    gbps_ram #(
        .WIDTH (EW),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbps_pkg::ST_CLEAR: begin
                if (w_clr_last) begin
                    n_state = r_set ? gbps_pkg::ST_SETUP : gbps_pkg::ST_IDLE;
                end
            end
            gbps_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = gbps_pkg::ST_SETUP;
                end
            end
            gbps_pkg::ST_SETUP: begin
                if (r_set) begin
                    // stamps about to wrap: wipe the store first
                    if (r_epoch == '1) begin
                        n_state = gbps_pkg::ST_CLEAR;
                    end
                end else if (w_limit || w_outside) begin
                    n_state = gbps_pkg::ST_IDLE;
                end else begin
                    n_state = gbps_pkg::ST_DIV;
                end
            end
            gbps_pkg::ST_DIV: begin
                if (w_done_x) begin
                    n_state = w_overflow ? gbps_pkg::ST_IDLE : gbps_pkg::ST_READ;
                end
            end
            gbps_pkg::ST_READ:  n_state = gbps_pkg::ST_CHECK;
            gbps_pkg::ST_CHECK: n_state = gbps_pkg::ST_IDLE;
            default:            n_state = gbps_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        w_emit        = 1'b0;
        w_verdict     = gbps_pkg::V_ACCEPT;
        w_div_start   = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_re      = 1'b0;
        w_mem_waddr   = r_addr;
        w_mem_wdata   = r_epoch;
        case (r_state)
            gbps_pkg::ST_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
            end
            gbps_pkg::ST_SETUP: begin
                if (!r_set) begin
                    if (w_limit) begin
                        w_emit    = 1'b1;
                        w_verdict = gbps_pkg::V_LIMIT;
                    end else if (w_outside) begin
                        w_emit    = 1'b1;
                        w_verdict = gbps_pkg::V_OUTSIDE;
                    end else begin
                        w_div_start = 1'b1;
                    end
                end
            end
            gbps_pkg::ST_DIV: begin
                if (w_done_x && w_overflow) begin
                    w_emit    = 1'b1;
                    w_verdict = gbps_pkg::V_OVERFLOW;
                end
            end
            gbps_pkg::ST_READ: begin
                w_mem_re = 1'b1;
            end
            gbps_pkg::ST_CHECK: begin
                w_emit = 1'b1;
                if (w_taken) begin
                    w_verdict = gbps_pkg::V_TAKEN;
                end else begin
                    w_mem_we = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbps_pkg::ST_CLEAR;
            r_set       <= 1'b0;
            r_count     <= '0;
            r_epoch     <= '0;
            r_clr_addr  <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= w_emit;
            if (w_accept_item) begin
                r_set <= i_start_set;
            end
            case (r_state)
                gbps_pkg::ST_CLEAR: begin
                    if (w_clr_last) begin
                        r_clr_addr <= '0;
                        r_epoch    <= EW'(1);
                        r_count    <= '0;
                        r_set      <= 1'b0;
                    end else begin
                        r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    end
                end
                gbps_pkg::ST_SETUP: begin
                    if (r_set && (r_epoch != '1)) begin
                        r_epoch <= r_epoch + EW'(1);
                        r_count <= '0;
                        r_set   <= 1'b0;
                    end
                end
                gbps_pkg::ST_CHECK: begin
                    if (!w_taken) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept_item) begin
            r_x <= i_pixel_x;
            r_y <= i_pixel_y;
        end
        if (r_state == gbps_pkg::ST_DIV && w_done_x) begin
            r_addr <= w_addr;
        end
        if (w_emit) begin
            r_res_accepted <= (w_verdict == gbps_pkg::V_ACCEPT);
            r_res_verdict  <= w_verdict;
            r_res_count    <= (w_verdict == gbps_pkg::V_ACCEPT) ? r_count + CW'(1) : r_count;
        end
    end

    assign busy             = (r_state != gbps_pkg::ST_IDLE);
    assign o_result_valid   = r_res_valid;
    assign o_accepted       = r_res_accepted;
    assign o_verdict        = r_res_verdict;
    assign o_selected_count = r_res_count;

    // ---------------- assertions ----------------
    a_lanes_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done_x == w_done_y)
        else $error("divider lanes out of step");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gbps_pkg::ST_CLEAR) |-> (r_epoch != '0))
        else $error("zero set stamp outside the wipe");

    a_accept_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gbps_pkg::ST_CHECK && !w_taken) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted item did not bump the count");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_idle_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while the sequencer still works");

endmodule

// ===== rtl/core/gbps_ram.sv =====
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module gbps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/gbps_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module gbps_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gbps_pkg::PIX_W-1:0]  i_dividend,
    input  logic [gbps_pkg::SCALE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [gbps_pkg::PIX_W-1:0]  o_quotient
);

    localparam int DW    = gbps_pkg::PIX_W;
    localparam int SW    = gbps_pkg::SCALE_W;
    localparam int CNT_W = $clog2(DW);

    logic             r_run;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]    r_q;
    logic [SW-1:0]    r_rem;
    logic [SW-1:0]    r_div;
    logic [SW:0]      w_trial;
    logic             w_fit;

    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DW - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            if (w_fit) begin
                r_rem <= SW'(w_trial - {1'b0, r_div});
            end else begin
                r_rem <= w_trial[SW-1:0];
            end
            r_q <= {r_q[DW-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== dv/tb_grid_bucketed_point_selector.sv =====
// testbench for grid_bucketed_point_selector: point stream against a predicted selection
`timescale 1ns / 1ps

module tb_grid_bucketed_point_selector;

    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int          TOTAL_ITEMS = 800;

    typedef struct {
        logic                         accepted;
        gbps_pkg::t_verdict           verdict;
        logic [gbps_pkg::COUNT_W-1:0] count;
    } t_selection;

    class point_selection_board;
        int         image_width  = 640;
        int         image_height = 480;
        int         cell_edge    = 16;
        int         max_points   = 150;
        int         selected_total;
        bit         taken_cells[int];
        t_selection pending_selections[$];
        int         error_count;

        function void set_register(gbps_pkg::t_cfg_index idx,
                                   logic [gbps_pkg::CFG_DAT_W-1:0] data);
            case (idx)
                gbps_pkg::CFG_IMAGE_WIDTH:  image_width  = int'(data[gbps_pkg::PIX_W-1:0]);
                gbps_pkg::CFG_IMAGE_HEIGHT: image_height = int'(data[gbps_pkg::PIX_W-1:0]);
                gbps_pkg::CFG_GRID_SCALE:   cell_edge    = int'(data[gbps_pkg::SCALE_W-1:0]);
                gbps_pkg::CFG_MAX_POINTS:   max_points   = int'(data[gbps_pkg::COUNT_W-1:0]);
                default: ;
            endcase
        endfunction

        // predicts the selection for one accepted item and queues it
        function void note_point(bit new_set, logic signed [gbps_pkg::COORD_W-1:0] px,
                                 logic signed [gbps_pkg::COORD_W-1:0] py);
            t_selection sel;
            int         ix, iy, step, cx, cy, cell_idx;
            ix = int'(px);
            iy = int'(py);
            if (new_set) begin
                taken_cells.delete();
                selected_total = 0;
            end
            if (selected_total >= max_points) begin
                sel.verdict = gbps_pkg::V_LIMIT;
            end else if (ix < 0 || iy < 0 || ix >= image_width || iy >= image_height) begin
                sel.verdict = gbps_pkg::V_OUTSIDE;
            end else begin
                step = (cell_edge == 0) ? 1 : cell_edge;
                cx = ix / step;
                cy = iy / step;
                cell_idx = cy * gbps_pkg::GRID_COLS_DEF + cx;
                if (cx >= gbps_pkg::GRID_COLS_DEF || cy >= gbps_pkg::GRID_ROWS_DEF) begin
                    sel.verdict = gbps_pkg::V_OVERFLOW;
                end else if (taken_cells.exists(cell_idx)) begin
                    sel.verdict = gbps_pkg::V_TAKEN;
                end else begin
                    taken_cells[cell_idx] = 1'b1;
                    selected_total++;
                    sel.verdict = gbps_pkg::V_ACCEPT;
                end
            end
            sel.accepted = (sel.verdict == gbps_pkg::V_ACCEPT);
            sel.count = gbps_pkg::COUNT_W'(selected_total);
            pending_selections = {pending_selections, sel};
        endfunction

        function void check_selection(logic accepted, logic [gbps_pkg::VERDICT_W-1:0] verdict,
                                      logic [gbps_pkg::COUNT_W-1:0] count);
            t_selection want;
            if (pending_selections.size() == 0) begin
                $error("result with no item awaiting one: verdict %0d count %0d",
                       verdict, count);
                error_count++;
                return;
            end
            want = pending_selections[0];
            pending_selections.delete(0);
            if (accepted !== want.accepted) begin
                $error("accepted: expected %0d, actual %0d", want.accepted, accepted);
                error_count++;
            end
            if (verdict !== want.verdict) begin
                $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
                error_count++;
            end
            if (count !== want.count) begin
                $error("selected_count: expected %0d, actual %0d", want.count, count);
                error_count++;
            end
        endfunction
    endclass

    logic                                  i_clk            = 1'b0;
    logic                                  i_rst_n          = 1'b0;
    logic                                  start            = 1'b0;
    logic                                  busy;
    logic                                  i_start_set      = 1'b0;
    logic signed [gbps_pkg::COORD_W-1:0]   i_pixel_x        = '0;
    logic signed [gbps_pkg::COORD_W-1:0]   i_pixel_y        = '0;
    logic                                  o_result_valid;
    logic                                  o_accepted;
    logic [gbps_pkg::VERDICT_W-1:0]        o_verdict;
    logic [gbps_pkg::COUNT_W-1:0]          o_selected_count;
    logic                                  i_cfg_valid      = 1'b0;
    logic                                  o_cfg_ready;
    logic [gbps_pkg::CFG_IDX_W-1:0]        i_cfg_index      = '0;
    logic [gbps_pkg::CFG_DAT_W-1:0]        i_cfg_data       = '0;

    point_selection_board board;
    int unsigned          cycle_count = 0;
    int                   items_sent  = 0;

    grid_bucketed_point_selector u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_start_set      (i_start_set),
        .i_pixel_x        (i_pixel_x),
        .i_pixel_y        (i_pixel_y),
        .o_result_valid   (o_result_valid),
        .o_accepted       (o_accepted),
        .o_verdict        (o_verdict),
        .o_selected_count (o_selected_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            board.check_selection(o_accepted, o_verdict, o_selected_count);
        end
    end

    // leaves start high; the next task lowers it or presents another item
    task automatic send_point(bit new_set, int px, int py);
        @(negedge i_clk);
        start       <= 1'b1;
        i_start_set <= new_set;
        i_pixel_x   <= gbps_pkg::COORD_W'(px);
        i_pixel_y   <= gbps_pkg::COORD_W'(py);
        do @(posedge i_clk); while (busy);
        board.note_point(new_set, gbps_pkg::COORD_W'(px), gbps_pkg::COORD_W'(py));
        items_sent++;
    endtask

    task automatic hold_off(int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (board.pending_selections.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(gbps_pkg::t_cfg_index idx,
                                  logic [gbps_pkg::CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // unused upper data bits get junk so the register masking is exercised
    task automatic configure(int width, int height, int scale, int limit);
        wait_idle();
        write_register(gbps_pkg::CFG_IMAGE_WIDTH,
                       gbps_pkg::CFG_DAT_W'(width | ($urandom_range(0, 7) << gbps_pkg::PIX_W)));
        write_register(gbps_pkg::CFG_IMAGE_HEIGHT,
                       gbps_pkg::CFG_DAT_W'(height | ($urandom_range(0, 7) << gbps_pkg::PIX_W)));
        write_register(gbps_pkg::CFG_GRID_SCALE,
                       gbps_pkg::CFG_DAT_W'(scale |
                                            ($urandom_range(0, 255) << gbps_pkg::SCALE_W)));
        write_register(gbps_pkg::CFG_MAX_POINTS, gbps_pkg::CFG_DAT_W'(limit));
    endtask

    function automatic int pick_coord(int edge_at);
        case ($urandom_range(0, 9))
            0: return int'($urandom_range(0, 65535)) - 32768;
            1: return edge_at + int'($urandom_range(0, 2)) - 1;
            default: return (edge_at > 0) ? int'($urandom_range(0, edge_at - 1)) : 0;
        endcase
    endfunction

    task automatic run_phase(int count, bit with_gaps);
        int set_left;
        bit new_set;
        set_left = 0;
        repeat (count) begin
            if (with_gaps && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 9));
            new_set = (set_left == 0) || ($urandom_range(0, 49) == 0);
            if (new_set) begin
                set_left = ($urandom_range(0, 2) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(1, 5);
            end
            set_left--;
            send_point(new_set, pick_coord(board.image_width), pick_coord(board.image_height));
        end
    endtask

    // many tiny sets in a few cells, pushing the set stamp past its wrap
    task automatic run_short_sets(int sets);
        repeat (sets) begin
            if ($urandom_range(0, 4) == 0) hold_off($urandom_range(1, 9));
            send_point(1'b1, int'($urandom_range(0, 31)), int'($urandom_range(0, 31)));
            if ($urandom_range(0, 1) == 1) begin
                send_point(1'b0, int'($urandom_range(0, 31)), int'($urandom_range(0, 31)));
            end
        end
    endtask

    initial begin
        int phase;
        int span;
        bit with_gaps;
        board = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: 640 x 480, 16 pixel cells, limit 150
        send_point(1'b1, 0, 0);
        send_point(1'b0, 0, 0);
        send_point(1'b0, 15, 15);
        send_point(1'b0, 16, 0);
        send_point(1'b0, 639, 479);
        send_point(1'b0, 640, 0);
        send_point(1'b0, 0, 480);
        send_point(1'b0, -1, 5);
        send_point(1'b0, 5, -32768);
        send_point(1'b0, 32767, 32767);
        send_point(1'b0, -32768, -1);
        send_point(1'b1, 639, 479);

        // largest image, zero scale, limit of two
        configure(8191, 8191, 0, 2);
        send_point(1'b1, 0, 0);
        send_point(1'b0, 8190, 8190);
        send_point(1'b0, 255, 255);
        send_point(1'b0, 256, 0);
        send_point(1'b1, 256, 0);
        send_point(1'b0, 1, 1);
        send_point(1'b0, 1, 1);

        // empty image
        configure(0, 0, 255, 65535);
        send_point(1'b1, 0, 0);
        send_point(1'b0, 100, 100);

        // zero limit wins over the bounds checks
        configure(8191, 8191, 255, 0);
        send_point(1'b1, 0, 0);
        send_point(1'b0, -1, -1);

        phase = 0;
        while (items_sent < TOTAL_ITEMS) begin
            if (phase == 2) begin
                configure(32, 32, 16, 65535);
                run_short_sets(270);
            end else begin
                case ((phase < 6) ? phase % 5 : $urandom_range(0, 4))
                    0: configure($urandom_range(1, 700), $urandom_range(1, 500),
                                 $urandom_range(1, 32), $urandom_range(1, 200));
                    1: configure($urandom_range(1, 40), $urandom_range(1, 40),
                                 $urandom_range(0, 8), 65535);
                    2: configure($urandom_range(4000, 8191), $urandom_range(4000, 8191),
                                 $urandom_range(0, 2), $urandom_range(100, 65535));
                    3: configure($urandom_range(1, 200), $urandom_range(1, 200),
                                 $urandom_range(1, 16), $urandom_range(0, 5));
                    default: configure($urandom_range(0, 8191), $urandom_range(0, 8191),
                                       $urandom_range(0, 255), $urandom_range(0, 65535));
                endcase
                span = TOTAL_ITEMS - items_sent;
                if (span > 60) span = 60;
                // the closing stretch runs without gaps
                with_gaps = (items_sent < TOTAL_ITEMS - 100) && ($urandom_range(0, 3) != 0);
                run_phase(span, with_gaps);
            end
            phase++;
        end

        wait_idle();
        repeat (40) @(negedge i_clk);
        if (board.pending_selections.size() != 0) begin
            $error("%0d results never arrived", board.pending_selections.size());
            board.error_count++;
        end
        if (board.error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
